### rtl/csa_pkg.sv
package csa_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	// entries popped and shown by print all
	localparam int ALL_N = (STACK_DEPTH < 8) ? STACK_DEPTH : 8;
	localparam int CNT_W = $clog2(ALL_N);
	localparam logic [PTR_W-1:0] ALL_STEP = PTR_W'(ALL_N % STACK_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);
	localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(STACK_DEPTH);

	localparam logic [4:0] OP_PUSH     = 5'd0;
	localparam logic [4:0] OP_DUP      = 5'd1;
	localparam logic [4:0] OP_DROP     = 5'd2;
	localparam logic [4:0] OP_BACK     = 5'd3;
	localparam logic [4:0] OP_SWAP     = 5'd4;
	localparam logic [4:0] OP_OVER     = 5'd5;
	localparam logic [4:0] OP_ADD      = 5'd6;
	localparam logic [4:0] OP_AND      = 5'd7;
	localparam logic [4:0] OP_OR       = 5'd8;
	localparam logic [4:0] OP_XOR      = 5'd9;
	localparam logic [4:0] OP_INVERT   = 5'd10;
	localparam logic [4:0] OP_NEGATE   = 5'd11;
	localparam logic [4:0] OP_PRINTDEC = 5'd12;
	localparam logic [4:0] OP_PRINTHEX = 5'd13;
	localparam logic [4:0] OP_ALLDEC   = 5'd14;
	localparam logic [4:0] OP_ALLHEX   = 5'd15;
	localparam logic [4:0] OP_SPEED    = 5'd16;
	localparam logic [4:0] OP_DELAY    = 5'd17;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_DEC    = 2'd1;
	localparam logic [1:0] KIND_HEX    = 2'd2;
	localparam logic [1:0] KIND_DELAY  = 2'd3;

	localparam logic [7:0] SPEED_RESET = 8'd15;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	// p - k modulo the depth, k below the depth
	function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] p,
			input logic [PTR_W-1:0] k);
		logic [PTR_W:0] w;
		w = {1'b0, p} + ((p < k) ? DEPTH_W : '0) - {1'b0, k};
		return w[PTR_W-1:0];
	endfunction

endpackage

### rtl/circular_stack_alu_core.sv
// Circular 16-bit data stack with a Forth word executor. Each input item carries one word
// code in s_tuser and a literal in s_tdata; the stack pointer wraps modulo the depth, so
// there is no overflow or underflow. The stack lives in a synchronous memory with two read
// ports and one write port and registered read data; every word is a read, modify, write back
// sequence followed by a read of the new top, which goes out with every result. One item
// is worked at a time: the word executes (swap then writes its second entry through the
// single write port), the new top is read and captured, and then the result is offered;
// s_tready rises again in the cycle after the last result is accepted. Print all emits
// eight results (or the depth, if smaller): each entry is read and captured before it is
// offered, and the next read starts once the result before it is accepted.
// An entry never written reads as zero through a per-entry valid bit.
module circular_stack_alu_core
	import csa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // literal
	input  logic [4:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // value, top_value, speed_value
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EX     = 3'd1;
	localparam logic [2:0] ST_WR2    = 3'd2;
	localparam logic [2:0] ST_TRD    = 3'd3;
	localparam logic [2:0] ST_VAL    = 3'd4;
	localparam logic [2:0] ST_ALLRD  = 3'd5;
	localparam logic [2:0] ST_ALLVAL = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0]             state_q;
	logic [PTR_W-1:0]       p_q;
	logic [PTR_W-1:0]       rp_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [7:0]             speed_q;
	logic [4:0]             op_q;
	logic [15:0]            lit_q;
	logic [15:0]            val_q;
	logic [1:0]             okind_q;
	logic [15:0]            oval_q;
	logic                   olast_q;
	logic [15:0]            top_q;

	logic [15:0]            mem [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] valid_q;
	logic [15:0]            rd0_q, rd1_q;
	logic                   rv0_q, rv1_q;
	logic [PTR_W-1:0]       raddr0, raddr1;

	logic                   we;
	logic [PTR_W-1:0]       waddr;
	logic [15:0]            wdata;
	logic [PTR_W-1:0]       p_nxt;

	logic [15:0]            a, b;
	logic                   all_op;
	logic                   in_acc, out_acc;

	assign a = rv0_q ? rd0_q : '0;
	assign b = rv1_q ? rd1_q : '0;
	assign all_op = (op_q == OP_ALLDEC) || (op_q == OP_ALLHEX);
	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {speed_q, top_q, oval_q};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

	// read the top and the entry below, or one print all entry
	always_comb begin
		raddr0 = p_q;
		raddr1 = ptr_dec(p_q);
		if (state_q == ST_ALLRD) begin
			raddr0 = ptr_sub(rp_q, PTR_W'(cnt_q));
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rv0_q   <= 1'b0;
			rv1_q   <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rv0_q <= valid_q[raddr0];
			rv1_q <= valid_q[raddr1];
		end
	end

	// word execution, a is the top and b the entry below
	always_comb begin
		we    = 1'b0;
		waddr = p_q;
		wdata = a;
		p_nxt = p_q;
		if (state_q == ST_WR2) begin
			we    = 1'b1;
			waddr = ptr_dec(p_q);
			wdata = val_q;
		end else if (state_q == ST_EX) begin
			case (op_q)
				OP_PUSH: begin
					we = 1'b1; waddr = ptr_inc(p_q); wdata = lit_q; p_nxt = ptr_inc(p_q);
				end
				OP_DUP: begin
					we = 1'b1; waddr = ptr_inc(p_q); wdata = a; p_nxt = ptr_inc(p_q);
				end
				OP_BACK: p_nxt = ptr_inc(p_q);
				OP_SWAP: begin
					we = 1'b1; waddr = p_q; wdata = b;
				end
				OP_OVER: begin
					we = 1'b1; waddr = ptr_inc(p_q); wdata = b; p_nxt = ptr_inc(p_q);
				end
				OP_ADD: begin
					we = 1'b1; waddr = ptr_dec(p_q); wdata = a + b; p_nxt = ptr_dec(p_q);
				end
				OP_AND: begin
					we = 1'b1; waddr = ptr_dec(p_q); wdata = a & b; p_nxt = ptr_dec(p_q);
				end
				OP_OR: begin
					we = 1'b1; waddr = ptr_dec(p_q); wdata = a | b; p_nxt = ptr_dec(p_q);
				end
				OP_XOR: begin
					we = 1'b1; waddr = ptr_dec(p_q); wdata = a ^ b; p_nxt = ptr_dec(p_q);
				end
				OP_INVERT: begin
					we = 1'b1; wdata = ~a;
				end
				OP_NEGATE: begin
					we = 1'b1; wdata = 16'd0 - a;
				end
				OP_DROP, OP_PRINTDEC, OP_PRINTHEX, OP_SPEED, OP_DELAY: p_nxt = ptr_dec(p_q);
				OP_ALLDEC, OP_ALLHEX: p_nxt = ptr_sub(p_q, ALL_STEP);
				default: p_nxt = p_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
			speed_q <= SPEED_RESET;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EX;
					end
				end
				ST_EX: begin
					p_q   <= p_nxt;
					rp_q  <= p_q;
					cnt_q <= '0;
					if (op_q == OP_SPEED) begin
						speed_q <= a[7:0];
					end
					state_q <= (op_q == OP_SWAP) ? ST_WR2 : ST_TRD;
				end
				ST_WR2:   state_q <= ST_TRD;
				ST_TRD:   state_q <= ST_VAL;
				ST_VAL:   state_q <= all_op ? ST_ALLRD : ST_OUT;
				ST_ALLRD: state_q <= ST_ALLVAL;
				ST_ALLVAL: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_acc) begin
						if (all_op && (cnt_q != CNT_W'(ALL_N - 1))) begin
							cnt_q   <= cnt_q + CNT_W'(1);
							state_q <= ST_ALLRD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= s_tuser;
			lit_q <= s_tdata;
		end
		if (state_q == ST_EX) begin
			val_q <= a;
		end
		if (state_q == ST_VAL) begin
			top_q   <= a;
			olast_q <= 1'b1;
			case (op_q)
				OP_PRINTDEC: begin
					okind_q <= KIND_DEC; oval_q <= val_q;
				end
				OP_PRINTHEX: begin
					okind_q <= KIND_HEX; oval_q <= val_q;
				end
				OP_DELAY: begin
					okind_q <= KIND_DELAY; oval_q <= val_q;
				end
				default: begin
					okind_q <= KIND_STATUS; oval_q <= '0;
				end
			endcase
		end
		if (state_q == ST_ALLVAL) begin
			okind_q <= (op_q == OP_ALLDEC) ? KIND_DEC : KIND_HEX;
			oval_q  <= a;
			olast_q <= (cnt_q == CNT_W'(ALL_N - 1));
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		p_q <= PTR_LAST)
		else $error("stack pointer out of range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready && !m_tvalid)
		else $error("accepted item not being executed");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && m_tlast |=> s_tready)
		else $error("block not idle after final result");

	a_more_after_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_tlast |=> state_q == ST_ALLRD)
		else $error("print all stopped before final result");

endmodule

### tb/sv/circular_stack_alu_core_tb.sv
`timescale 1ns / 100ps

module circular_stack_alu_core_tb;
	import csa_pkg::*;

	localparam logic [4:0] OP_NOP       = 5'd18;
	localparam logic [4:0] OP_UNUSED_LO = 5'd19;
	localparam logic [4:0] OP_UNUSED_HI = 5'd31;
	localparam int PRINT_ALL_MAX = 8;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 80;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] value;
		logic        last;
		logic [15:0] top_value;
		logic [7:0]  speed_value;
	} word_result_t;

	class word_scoreboard;
		logic [15:0]  cells [STACK_DEPTH];
		int           tos;
		logic [7:0]   speed;
		word_result_t pending_results [$];
		int           errors;

		function new();
			foreach (cells[i]) cells[i] = '0;
			tos = 0;
			speed = SPEED_RESET;
			errors = 0;
		endfunction

		function void push_cell(logic [15:0] v);
			tos = (tos + 1) % STACK_DEPTH;
			cells[tos] = v;
		endfunction

		function logic [15:0] pop_cell();
			logic [15:0] v;
			v = cells[tos];
			tos = (tos + STACK_DEPTH - 1) % STACK_DEPTH;
			return v;
		endfunction

		// run one word on the shadow stack and queue the results it gives
		function void accept_word(logic [4:0] op, logic [15:0] lit);
			logic [1:0]   kinds [PRINT_ALL_MAX];
			logic [15:0]  vals [PRINT_ALL_MAX];
			logic [15:0]  a, b;
			int           n;
			word_result_t r;
			n = 1;
			kinds[0] = KIND_STATUS;
			vals[0] = '0;
			case (op)
				OP_PUSH: push_cell(lit);
				OP_DUP: push_cell(cells[tos]);
				OP_DROP: a = pop_cell();
				OP_BACK: tos = (tos + 1) % STACK_DEPTH;
				OP_SWAP: begin
					a = pop_cell();
					b = pop_cell();
					push_cell(a);
					push_cell(b);
				end
				OP_OVER: begin
					a = pop_cell();
					b = pop_cell();
					push_cell(b);
					push_cell(a);
					push_cell(b);
				end
				OP_ADD: begin
					a = pop_cell();
					cells[tos] = a + cells[tos];
				end
				OP_AND: begin
					a = pop_cell();
					cells[tos] = a & cells[tos];
				end
				OP_OR: begin
					a = pop_cell();
					cells[tos] = a | cells[tos];
				end
				OP_XOR: begin
					a = pop_cell();
					cells[tos] = a ^ cells[tos];
				end
				OP_INVERT: cells[tos] = ~cells[tos];
				OP_NEGATE: cells[tos] = 16'd0 - cells[tos];
				OP_PRINTDEC: begin
					kinds[0] = KIND_DEC;
					vals[0] = pop_cell();
				end
				OP_PRINTHEX: begin
					kinds[0] = KIND_HEX;
					vals[0] = pop_cell();
				end
				OP_ALLDEC, OP_ALLHEX: begin
					n = (STACK_DEPTH < PRINT_ALL_MAX) ? STACK_DEPTH : PRINT_ALL_MAX;
					for (int k = 0; k < n; k++) begin
						kinds[k] = (op == OP_ALLDEC) ? KIND_DEC : KIND_HEX;
						vals[k] = pop_cell();
					end
				end
				OP_SPEED: begin
					a = pop_cell();
					speed = a[7:0];
				end
				OP_DELAY: begin
					kinds[0] = KIND_DELAY;
					vals[0] = pop_cell();
				end
				default: ;
			endcase
			for (int k = 0; k < n; k++) begin
				r.kind = kinds[k];
				r.value = vals[k];
				r.last = (k == n - 1);
				r.top_value = cells[tos];
				r.speed_value = speed;
				pending_results.push_back(r);
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(word_result_t got);
			word_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("kind", 16'(want.kind), 16'(got.kind));
			compare_field("value", want.value, got.value);
			compare_field("last", 16'(want.last), 16'(got.last));
			compare_field("top_value", want.top_value, got.top_value);
			compare_field("speed_value", 16'(want.speed_value), 16'(got.speed_value));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	word_scoreboard sb = new();
	int cycle_count = 0;
	int hold_off = 0;
	bit steady = 0;

	circular_stack_alu_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(logic [4:0] op, logic [15:0] lit, int gap);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= lit;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.accept_word(op, lit);
	endtask

	task automatic send_random_word(int gap);
		logic [4:0]  op;
		logic [15:0] lit;
		int          r;
		r = $urandom_range(0, 99);
		lit = 16'($urandom());
		if (r < 30)
			op = OP_PUSH;
		else if (r < 92)
			op = 5'($urandom_range(1, 18));
		else
			op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		// edge values now and then
		if ($urandom_range(0, 3) == 0)
			lit = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7fff;
		send_word(op, lit, gap);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int  len;
		bit  rdy;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				len = hold_off;
				hold_off = 0;
				rdy = 1'b0;
			end else if (steady) begin
				len = 1;
				rdy = 1'b1;
			end else begin
				rdy = ($urandom_range(0, 99) < 65);
				len = rdy ? $urandom_range(1, 6) : pick_gap() + 1;
			end
			m_tready <= rdy;
			repeat (len - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		word_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.value = m_tdata[15:0];
			got.last = m_tlast;
			got.top_value = m_tdata[31:16];
			got.speed_value = m_tdata[39:32];
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		logic [4:0]  dir_ops [26];
		logic [15:0] dir_lits [6];
		dir_ops = '{OP_PUSH, OP_PUSH, OP_PUSH, OP_PUSH, OP_PUSH, OP_PUSH,
			OP_DUP, OP_OVER, OP_SWAP, OP_ADD, OP_AND, OP_OR, OP_XOR, OP_INVERT,
			OP_NEGATE, OP_PRINTDEC, OP_PRINTHEX, OP_BACK, OP_DROP, OP_SPEED,
			OP_DELAY, OP_ALLDEC, OP_ALLHEX, OP_NOP, OP_UNUSED_LO, OP_UNUSED_HI};
		dir_lits = '{16'h7fff, 16'h8000, 16'hffff, 16'h0000, 16'ha5a5, 16'h5a5a};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: six pushes of extreme and pattern literals, then every other word once, a nop and unused codes
		foreach (dir_ops[i])
			send_word(dir_ops[i], (i < 6) ? dir_lits[i] : 16'($urandom()), pick_gap());

		// stalled output: a long m_tready hold-off while twelve items are offered back to back
		hold_off = HOLD_CYCLES;
		repeat (12) send_random_word(0);

		for (int i = 0; i < 62; i++) begin
			steady = (i >= 20 && i < 40);
			send_random_word(pick_gap());
		end
		steady = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
